// ===== src/mme_pkg.sv =====
// ----------------------------------------------------------------------------
// mme_pkg
// Shared widths, codes and types of the matrix multiply engine.
// ----------------------------------------------------------------------------
package mme_pkg;

   // Field widths of the request and response words
   localparam int ACT_W     = 2;
   localparam int IDX_W     = 6;
   localparam int VAL_W     = 16;
   localparam int SUM_W     = 40;
   localparam int DIM_W     = 7;
   localparam int CSR_IDX_W = 2;

   // Request actions
   localparam logic [ACT_W-1:0] ACT_WRITE_A = 2'd0;
   localparam logic [ACT_W-1:0] ACT_WRITE_B = 2'd1;
   localparam logic [ACT_W-1:0] ACT_COMPUTE = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_A_ROWS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INNER_LEN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_B_COLS    = 2'd2;

   localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

   // Control of the accumulator ring for one product
   typedef struct packed {
      logic shift_en;   // a product enters the head cell
      logic clear;      // first pass over the inner dimension: start from zero
   } ring_ctl_type;

   // Tag carried alongside each product through the datapath
   typedef struct packed {
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic             first_pass;
      logic             last_pass;
      logic             last_col;
      logic             zero_term;
   } tag_type;

endpackage

// ===== src/mme_if.sv =====
// ----------------------------------------------------------------------------
// mme_req_if / mme_rsp_if
// Valid/ready channels for request and response words.
// ----------------------------------------------------------------------------
interface mme_req_if;
   logic                                valid;
   logic                                ready;
   logic        [mme_pkg::ACT_W-1:0]    action;
   logic        [mme_pkg::IDX_W-1:0]    row_sel;
   logic        [mme_pkg::IDX_W-1:0]    col_sel;
   logic signed [mme_pkg::VAL_W-1:0]    elem_value;

   modport source (output valid, output action, output row_sel, output col_sel,
                   output elem_value, input ready);
   modport sink   (input valid, input action, input row_sel, input col_sel,
                   input elem_value, output ready);
endinterface

interface mme_rsp_if;
   logic                                valid;
   logic                                ready;
   logic        [mme_pkg::IDX_W-1:0]    out_row;
   logic        [mme_pkg::IDX_W-1:0]    out_col;
   logic signed [mme_pkg::SUM_W-1:0]    dot_sum;
   logic                                row_last;

   modport source (output valid, output out_row, output out_col, output dot_sum,
                   output row_last, input ready);
   modport sink   (input valid, input out_row, input out_col, input dot_sum,
                   input row_last, output ready);
endinterface

// ===== src/mme_cell.sv =====
// ----------------------------------------------------------------------------
// mme_cell
// One accumulator cell of the ring: optionally adds a product to the value
// handed in by its neighbour, and holds the result for the next cell.
// ----------------------------------------------------------------------------
module mme_cell (
   input  logic                              clock,
   input  logic                              enable,
   input  logic                              add_en,
   input  logic signed [mme_pkg::SUM_W-1:0]  shift_in,
   input  logic signed [mme_pkg::SUM_W-1:0]  addend,
   output logic signed [mme_pkg::SUM_W-1:0]  acc_out,
   output logic signed [mme_pkg::SUM_W-1:0]  sum_out
);

   logic signed [mme_pkg::SUM_W-1:0] acc_ff;
   logic signed [mme_pkg::SUM_W-1:0] acc_in;

   always_comb begin
      acc_in = add_en ? shift_in + addend : shift_in;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         acc_ff <= acc_in;
      end
   end

   assign acc_out = acc_ff;
   assign sum_out = acc_in;

endmodule

// ===== src/mme_ring.sv =====
// ----------------------------------------------------------------------------
// mme_ring
// Chain of accumulator cells closed into a ring of selectable length, one
// partial sum per result column circulating past the head cell.
// ----------------------------------------------------------------------------
module mme_ring #(
   parameter int NUM_CELLS = 64,
   parameter int TAP_W     = 6
) (
   input  logic                              clock,
   input  mme_pkg::ring_ctl_type             ctl,
   input  logic signed [mme_pkg::SUM_W-1:0]  addend,
   input  logic        [TAP_W-1:0]           tap_sel,
   output logic signed [mme_pkg::SUM_W-1:0]  head_sum
);

   logic signed [mme_pkg::SUM_W-1:0] acc      [NUM_CELLS];
   logic signed [mme_pkg::SUM_W-1:0] chain_in [NUM_CELLS];
   logic signed [mme_pkg::SUM_W-1:0] cell_sum [NUM_CELLS];
   logic signed [mme_pkg::SUM_W-1:0] tap;

   // The cell at index ring length minus one feeds back into the head
   assign tap = acc[tap_sel];

   for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
      if (c == 0) begin : g_head
         assign chain_in[c] = ctl.clear ? '0 : tap;
      end else begin : g_body
         assign chain_in[c] = acc[c-1];
      end

      mme_cell u_cell (
         .clock    (clock),
         .enable   (ctl.shift_en),
         .add_en   (1'(c == 0)),
         .shift_in (chain_in[c]),
         .addend   (addend),
         .acc_out  (acc[c]),
         .sum_out  (cell_sum[c])
      );
   end

   assign head_sum = cell_sum[0];

endmodule

// ===== src/matrix_multiply_engine_top.sv =====
// ----------------------------------------------------------------------------
// matrix_multiply_engine_top
// Row-at-a-time matrix multiply over two element stores.
// ----------------------------------------------------------------------------
// Load words write one element of A or B. A compute word for row i streams
// max(K,1) x N products through one multiplier, B-store column index
// fastest, through a pipeline of memory read, multiply and accumulate, with
// no new word taken until the last product has entered the accumulator ring;
// the B store has a single read port feeding the one multiply-accumulate.
// The N partial sums circulate in a ring of accumulator cells cut to length
// N, and each column's sum leaves on its final pass. A response stall
// freezes the whole datapath. The stores are not cleared at reset; only
// written entries may be used in a compute.
module matrix_multiply_engine_top #(
   parameter int MAX_ROWS   = 64,
   parameter int MAX_INNER  = 64,
   parameter int MAX_COLS   = 64,
   parameter int ELEM_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   mme_req_if.sink                           req_if,
   mme_rsp_if.source                         rsp_if,
   input  logic                              csr_we,
   input  logic [mme_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mme_pkg::DIM_W-1:0]         csr_wdata
);

   localparam int A_DEPTH = MAX_ROWS * MAX_INNER;
   localparam int B_DEPTH = MAX_INNER * MAX_COLS;
   localparam int A_AW    = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
   localparam int B_AW    = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
   localparam int TAP_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int PROD_W  = 2 * ELEM_WIDTH;
   localparam int EXT_W   = (ELEM_WIDTH > mme_pkg::VAL_W) ? ELEM_WIDTH : mme_pkg::VAL_W;
   localparam int DIM_W   = mme_pkg::DIM_W;
   localparam int IDX_W   = mme_pkg::IDX_W;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   // ---------------------------------------------------------------- config
   logic [DIM_W-1:0] a_rows_ff, a_rows_in;
   logic [DIM_W-1:0] inner_len_ff, inner_len_in;
   logic [DIM_W-1:0] b_cols_ff, b_cols_in;

   always_comb begin
      a_rows_in    = a_rows_ff;
      inner_len_in = inner_len_ff;
      b_cols_in    = b_cols_ff;
      if (csr_we) begin
         unique case (csr_index)
            mme_pkg::REG_A_ROWS:    a_rows_in    = csr_wdata;
            mme_pkg::REG_INNER_LEN: inner_len_in = csr_wdata;
            mme_pkg::REG_B_COLS:    b_cols_in    = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_rows_ff    <= mme_pkg::DIM_RESET;
         inner_len_ff <= mme_pkg::DIM_RESET;
         b_cols_ff    <= mme_pkg::DIM_RESET;
      end else begin
         a_rows_ff    <= a_rows_in;
         inner_len_ff <= inner_len_in;
         b_cols_ff    <= b_cols_in;
      end
   end

   // Saturate each dimension to the store size
   logic [DIM_W-1:0] m_eff, k_eff, n_eff, k_last, n_last;

   assign m_eff  = (32'(a_rows_ff) > MAX_ROWS) ? DIM_W'(MAX_ROWS) : a_rows_ff;
   assign k_eff  = (32'(inner_len_ff) > MAX_INNER) ? DIM_W'(MAX_INNER) : inner_len_ff;
   assign n_eff  = (32'(b_cols_ff) > MAX_COLS) ? DIM_W'(MAX_COLS) : b_cols_ff;
   assign k_last = (k_eff == '0) ? '0 : k_eff - 1'b1;
   assign n_last = n_eff - 1'b1;

   // -------------------------------------------------------------- requests
   logic             state_ff, state_in;
   logic             s1_vld_ff, s2_vld_ff, out_vld_ff, out_vld_in;
   logic             adv;
   logic             req_fire;
   logic [DIM_W-1:0] req_row, req_col;
   logic             wr_a, wr_b, start;
   logic [EXT_W-1:0] wr_ext;
   logic [ELEM_WIDTH-1:0] wr_val;
   logic [A_AW-1:0]  a_waddr, a_raddr;
   logic [B_AW-1:0]  b_waddr, b_raddr;

   assign req_if.ready = (state_ff == ST_IDLE) && !s1_vld_ff && !s2_vld_ff;
   assign req_fire     = req_if.valid && req_if.ready;
   assign req_row      = DIM_W'(req_if.row_sel);
   assign req_col      = DIM_W'(req_if.col_sel);

   assign wr_a  = req_fire && (req_if.action == mme_pkg::ACT_WRITE_A)
                  && (req_row < m_eff) && (req_col < k_eff);
   assign wr_b  = req_fire && (req_if.action == mme_pkg::ACT_WRITE_B)
                  && (req_row < k_eff) && (req_col < n_eff);
   assign start = req_fire && (req_if.action == mme_pkg::ACT_COMPUTE)
                  && (req_row < m_eff) && (n_eff != '0);

   // Elements are kept at ELEM_WIDTH bits, two's complement
   assign wr_ext = EXT_W'(unsigned'(req_if.elem_value));
   assign wr_val = wr_ext[ELEM_WIDTH-1:0];

   assign a_waddr = A_AW'(32'(req_if.row_sel) * MAX_INNER + 32'(req_if.col_sel));
   assign b_waddr = B_AW'(32'(req_if.row_sel) * MAX_COLS + 32'(req_if.col_sel));

   // ------------------------------------------------------------- sequencer
   logic [IDX_W-1:0] row_ff;
   logic [DIM_W-1:0] t_ff, t_in, j_ff, j_in;
   logic             zero_ff;
   logic             issue, run_done;
   mme_pkg::tag_type issue_tag;

   // A stall on the response side freezes every stage
   assign adv      = !out_vld_ff || rsp_if.ready;
   assign issue    = (state_ff == ST_RUN);
   assign run_done = (j_ff == n_last) && (t_ff == k_last);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (start) begin
            state_in = ST_RUN;
         end
         ST_RUN: if (adv && run_done) begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      t_in = t_ff;
      j_in = j_ff;
      if (start) begin
         t_in = '0;
         j_in = '0;
      end else if (issue && adv) begin
         if (j_ff == n_last) begin
            j_in = '0;
            t_in = t_ff + 1'b1;
         end else begin
            j_in = j_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff <= t_in;
      j_ff <= j_in;
      if (start) begin
         row_ff  <= req_if.row_sel;
         zero_ff <= (k_eff == '0);
      end
   end

   assign a_raddr = A_AW'(32'(row_ff) * MAX_INNER + 32'(t_ff));
   assign b_raddr = B_AW'(32'(t_ff) * MAX_COLS + 32'(j_ff));

   always_comb begin
      issue_tag.row        = row_ff;
      issue_tag.col        = IDX_W'(j_ff);
      issue_tag.first_pass = (t_ff == '0);
      issue_tag.last_pass  = (t_ff == k_last);
      issue_tag.last_col   = (j_ff == n_last);
      issue_tag.zero_term  = zero_ff;
   end

   // ---------------------------------------------------------------- stores
   logic [ELEM_WIDTH-1:0] a_mem [A_DEPTH];
   logic [ELEM_WIDTH-1:0] b_mem [B_DEPTH];
   logic signed [ELEM_WIDTH-1:0] a_rd_ff, b_rd_ff;

   always_ff @(posedge clock) begin
      if (wr_a) begin
         a_mem[a_waddr] <= wr_val;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_rd_ff <= a_mem[a_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_b) begin
         b_mem[b_waddr] <= wr_val;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_rd_ff <= b_mem[b_raddr];
      end
   end

   // -------------------------------------------------------------- datapath
   mme_pkg::tag_type          s1_tag_ff, s2_tag_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [PROD_W-1:0]  mul_res;

   // Signed product formed on its own so the zero select cannot unsign it
   assign mul_res = a_rd_ff * b_rd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= issue;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_tag_ff <= issue_tag;
         s2_tag_ff <= s1_tag_ff;
         // Empty inner dimension: every term is zero
         prod_ff   <= s1_tag_ff.zero_term ? '0 : mul_res;
      end
   end

   mme_pkg::ring_ctl_type            ring_ctl;
   logic signed [mme_pkg::SUM_W-1:0] ring_addend;
   logic signed [mme_pkg::SUM_W-1:0] head_sum;
   logic        [TAP_W-1:0]          tap_sel;

   assign ring_ctl.shift_en = adv && s2_vld_ff;
   assign ring_ctl.clear    = s2_tag_ff.first_pass;
   assign ring_addend       = mme_pkg::SUM_W'(prod_ff);
   assign tap_sel           = TAP_W'(n_eff - 1'b1);

   mme_ring #(
      .NUM_CELLS (MAX_COLS),
      .TAP_W     (TAP_W)
   ) u_ring (
      .clock    (clock),
      .ctl      (ring_ctl),
      .addend   (ring_addend),
      .tap_sel  (tap_sel),
      .head_sum (head_sum)
   );

   // ---------------------------------------------------------------- output
   logic [IDX_W-1:0]                 out_row_ff, out_col_ff;
   logic signed [mme_pkg::SUM_W-1:0] out_sum_ff;
   logic                             out_last_ff;
   logic                             out_load;

   assign out_load   = adv && s2_vld_ff && s2_tag_ff.last_pass;
   assign out_vld_in = adv ? (s2_vld_ff && s2_tag_ff.last_pass) : out_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_row_ff  <= s2_tag_ff.row;
         out_col_ff  <= s2_tag_ff.col;
         out_sum_ff  <= head_sum;
         out_last_ff <= s2_tag_ff.last_col;
      end
   end

   assign rsp_if.valid    = out_vld_ff;
   assign rsp_if.out_row  = out_row_ff;
   assign rsp_if.out_col  = out_col_ff;
   assign rsp_if.dot_sum  = out_sum_ff;
   assign rsp_if.row_last = out_last_ff;

endmodule

// ===== src/mme_checker.sv =====
// ----------------------------------------------------------------------------
// mme_checker
// Port-level checks of the matrix multiply engine, bound to the top level.
// ----------------------------------------------------------------------------
module mme_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic [mme_pkg::ACT_W-1:0]         req_action,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [mme_pkg::IDX_W-1:0]         rsp_out_row,
   input logic [mme_pkg::IDX_W-1:0]         rsp_out_col,
   input logic signed [mme_pkg::SUM_W-1:0]  rsp_dot_sum,
   input logic                              rsp_row_last
);

   // Hold a stalled response word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_row)
         && $stable(rsp_out_col) && $stable(rsp_dot_sum) && $stable(rsp_row_last))
      else $error("response word changed while stalled");

   // A load word leaves the engine ready in the next cycle
   a_load_ready: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready
         && (req_action == mme_pkg::ACT_WRITE_A || req_action == mme_pkg::ACT_WRITE_B)
      |=> req_ready)
      else $error("engine not ready after a load word");

   // No new request while a row is still being emitted
   a_row_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_row_last |-> !req_ready)
      else $error("request taken in the middle of a result row");

   // Reset drops any pending response
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind matrix_multiply_engine_top mme_checker u_mme_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_if.valid),
   .req_ready    (req_if.ready),
   .req_action   (req_if.action),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .rsp_out_row  (rsp_if.out_row),
   .rsp_out_col  (rsp_if.out_col),
   .rsp_dot_sum  (rsp_if.dot_sum),
   .rsp_row_last (rsp_if.row_last)
);
